>>> hdl/plk_pkg.sv
// shared types and constants for the piecewise linear lookup
package plk_pkg;

  localparam int MAX_KNOTS = 1024;
  localparam int IDX_W     = $clog2(MAX_KNOTS);
  localparam int CNT_W     = $clog2(MAX_KNOTS + 1);
  localparam int DATA_W    = 32;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ORDER = 2'd3;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [DATA_W-1:0]        key;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] estimate;
    logic [1:0]               status;
  } out_t;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } knot_t;

endpackage

>>> hdl/piecewise_linear_lookup.sv
// piecewise linear lookup top level: request sequencer, knot table and divider
//
//  port group  dir  handshake        payload
//  in_         in   valid / stall    plk_pkg::in_t  (req_type, key, value)
//  out_        out  valid / stall    plk_pkg::out_t (estimate, status)
//
// clear, append and clamped queries: the result register is loaded in the emit state that follows
//   the transfer, once the output register is free; the next input transfer follows the return to idle
// interpolating query: a read state and a compare state per binary search step (10 steps at 1024 knots),
//   then last read, two knot fetches, multiply, divider start and wait, and result load
// exact key match skips the divider
// reset empties the table; knot memory contents are not cleared; input stalled in reset
// a held result in the output register does not block the next input transfer
module piecewise_linear_lookup (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  plk_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output plk_pkg::out_t out_data
);

  localparam int IW = plk_pkg::IDX_W;
  localparam int CW = plk_pkg::CNT_W;
  localparam int W  = plk_pkg::DATA_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_CMP, S_FETCH_HI, S_FETCH_LO,
    S_MUL, S_DSTART, S_DWAIT, S_EMIT
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   cnt_r;
  logic [W-1:0]    first_key_r;
  logic [W-1:0]    first_val_r;
  logic [W-1:0]    last_key_r;
  logic [W-1:0]    last_val_r;
  logic [W-1:0]    q_r;
  logic [IW-1:0]   lo_r;
  logic [IW-1:0]   hi_r;
  logic [W-1:0]    k1_r;
  logic [W-1:0]    y1_r;
  logic [W-1:0]    y0_r;
  logic [W-1:0]    dx_r;
  logic [W-1:0]    ofs_r;
  logic [W:0]      dy_r;
  logic [2*W-1:0]  prod_r;
  plk_pkg::out_t   res_r;
  logic            out_valid_r;
  plk_pkg::out_t   out_data_r;

  logic            accept;
  logic            out_free;
  logic            out_load;
  logic [IW-1:0]   mid;
  logic            mem_wr_en;
  logic            mem_rd_en;
  logic [IW-1:0]   mem_rd_addr;
  plk_pkg::knot_t  mem_wr_data;
  plk_pkg::knot_t  mem_rd_data;
  logic            app_full;
  logic            app_order;
  plk_pkg::out_t   idle_res;
  logic            go_search;
  logic            dy_neg;
  logic [W-1:0]    dy_mag;
  logic            div_start;
  logic            div_done;
  logic [W-1:0]    div_quot;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = !rst_n || state_r != S_IDLE;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = state_r == S_EMIT && out_free;
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign app_full  = cnt_r == CW'(plk_pkg::MAX_KNOTS);
  assign app_order = cnt_r != '0 && in_data.key <= last_key_r;
  assign div_start = state_r == S_DSTART;

  always_comb begin
    mem_wr_en         = accept && in_data.req_type == plk_pkg::REQ_APPEND
                        && !app_full && !app_order;
    mem_wr_data.key   = in_data.key;
    mem_wr_data.value = in_data.value;
    mem_rd_en         = 1'b0;
    mem_rd_addr       = lo_r;
    case (state_r)
      S_SEARCH: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = (lo_r == hi_r) ? lo_r : mid;
      end
      S_FETCH_HI: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = lo_r - IW'(1);
      end
      default: begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = lo_r;
      end
    endcase
  end

  // result of a request that completes without the search
  always_comb begin
    idle_res.estimate = '0;
    idle_res.status   = plk_pkg::ST_OK;
    go_search         = 1'b0;
    case (in_data.req_type)
      plk_pkg::REQ_APPEND: begin
        if (app_full) begin
          idle_res.status = plk_pkg::ST_FULL;
        end else if (app_order) begin
          idle_res.status = plk_pkg::ST_ORDER;
        end
      end
      plk_pkg::REQ_QUERY: begin
        if (cnt_r == '0) begin
          idle_res.status = plk_pkg::ST_EMPTY;
        end else if (in_data.key <= first_key_r) begin
          idle_res.estimate = first_val_r;
        end else if (in_data.key >= last_key_r) begin
          idle_res.estimate = last_val_r;
        end else begin
          go_search = 1'b1;
        end
      end
      default: begin
        idle_res.status = plk_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_r   <= idle_res;
            state_r <= go_search ? S_SEARCH : S_EMIT;
            q_r     <= in_data.key;
            lo_r    <= IW'(1);
            hi_r    <= IW'(cnt_r - CW'(1));
            if (in_data.req_type == plk_pkg::REQ_CLEAR) begin
              cnt_r <= '0;
            end else if (mem_wr_en) begin
              cnt_r      <= cnt_r + CW'(1);
              last_key_r <= in_data.key;
              last_val_r <= in_data.value;
              if (cnt_r == '0) begin
                first_key_r <= in_data.key;
                first_val_r <= in_data.value;
              end
            end
          end
        end
        S_SEARCH: begin
          state_r <= (lo_r == hi_r) ? S_FETCH_HI : S_CMP;
        end
        S_CMP: begin
          if (mem_rd_data.key < q_r) begin
            lo_r <= mid + IW'(1);
          end else begin
            hi_r <= mid;
          end
          state_r <= S_SEARCH;
        end
        S_FETCH_HI: begin
          if (mem_rd_data.key == q_r) begin
            res_r.estimate <= mem_rd_data.value;
            state_r        <= S_EMIT;
          end else begin
            k1_r    <= mem_rd_data.key;
            y1_r    <= mem_rd_data.value;
            state_r <= S_FETCH_LO;
          end
        end
        S_FETCH_LO: begin
          dx_r    <= k1_r - mem_rd_data.key;
          ofs_r   <= q_r - mem_rd_data.key;
          y0_r    <= mem_rd_data.value;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= {{W{1'b0}}, dy_mag} * {{W{1'b0}}, ofs_r};
          state_r <= S_DSTART;
        end
        S_DSTART: begin
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            res_r.estimate <= dy_neg ? y0_r - div_quot : y0_r + div_quot;
            state_r        <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // signed slope numerator, taken from the high and low knot values
  always_ff @(posedge clk) begin
    if (state_r == S_FETCH_LO) begin
      dy_r <= {y1_r[W-1], y1_r} - {mem_rd_data.value[W-1], mem_rd_data.value};
    end
  end

  always_comb begin
    dy_neg = dy_r[W];
    dy_mag = dy_r[W] ? W'(-dy_r) : dy_r[W-1:0];
  end

  plk_knot_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (cnt_r[IW-1:0]),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  plk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (dx_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(plk_pkg::MAX_KNOTS)) else $error("knot count past table size");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH || state_r == S_CMP || state_r == S_FETCH_HI)
      |-> lo_r != '0 && lo_r <= hi_r) else $error("search window out of range");

  a_div_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWAIT && div_done) |=> state_r == S_EMIT)
    else $error("division result dropped");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> out_valid_r && state_r == S_IDLE)
    else $error("result not loaded into output register");

endmodule

>>> hdl/plk_knot_mem.sv
// knot table memory, one write port and one registered read port
module plk_knot_mem (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [plk_pkg::IDX_W-1:0] wr_addr,
  input  plk_pkg::knot_t           wr_data,
  input  logic                     rd_en,
  input  logic [plk_pkg::IDX_W-1:0] rd_addr,
  output plk_pkg::knot_t           rd_data
);

  plk_pkg::knot_t mem [plk_pkg::MAX_KNOTS];
  plk_pkg::knot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/plk_div.sv
// iterative restoring divider, one quotient bit per cycle, quotient known to fit 32 bits
module plk_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [2*plk_pkg::DATA_W-1:0]   dividend,
  input  logic [plk_pkg::DATA_W-1:0]     divisor,
  output logic                           done,
  output logic [plk_pkg::DATA_W-1:0]     quotient
);

  localparam int W      = plk_pkg::DATA_W;
  localparam int STEP_W = $clog2(W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [W-1:0]      rem_r;
  logic [W-1:0]      acc_r;
  logic [W-1:0]      dvs_r;
  logic [W:0]        trial;
  logic [W:0]        diff;
  logic              ge;

  always_comb begin
    trial = {rem_r, acc_r[W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == STEP_W'(W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= dividend[2*W-1:W];
      acc_r <= dividend[W-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r + STEP_W'(1);
      rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
      acc_r <= {acc_r[W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r) else $error("divider done without run");

endmodule

>>> sim/tb_top.sv
// self-checking testbench for the piecewise linear lookup: table build, query and status checks
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    plk_pkg::in_t req;
    bit           drain;
  } pending_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  plk_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  plk_pkg::out_t out_data;

  pending_t      request_q[$];
  plk_pkg::out_t awaited_results[$];
  logic [31:0]   built_keys[$];

  logic [31:0]        tbl_keys[plk_pkg::MAX_KNOTS];
  logic signed [31:0] tbl_vals[plk_pkg::MAX_KNOTS];
  int                 tbl_count = 0;

  bit in_fired = 1'b0;
  int errors = 0;
  int in_count = 0;
  int out_count = 0;
  int n_interp = 0;
  int n_status[4] = '{0, 0, 0, 0};

  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  int holdoffs_done = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int fill_start;

  piecewise_linear_lookup i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic plk_pkg::out_t apply_request(plk_pkg::in_t r);
    plk_pkg::out_t res;
    int unsigned   last, lo, hi, mid;
    logic [31:0]   dx, ofs;
    longint        y0, y1, dy, est;
    logic [63:0]   mag, quot;
    res.estimate = '0;
    res.status   = plk_pkg::ST_OK;
    case (r.req_type)
      plk_pkg::REQ_CLEAR: tbl_count = 0;
      plk_pkg::REQ_APPEND: begin
        if (tbl_count >= plk_pkg::MAX_KNOTS) begin
          res.status = plk_pkg::ST_FULL;
        end else if (tbl_count > 0 && r.key <= tbl_keys[tbl_count-1]) begin
          res.status = plk_pkg::ST_ORDER;
        end else begin
          tbl_keys[tbl_count] = r.key;
          tbl_vals[tbl_count] = r.value;
          tbl_count++;
        end
      end
      plk_pkg::REQ_QUERY: begin
        if (tbl_count == 0) begin
          res.status = plk_pkg::ST_EMPTY;
        end else begin
          last = tbl_count - 1;
          if (r.key <= tbl_keys[0]) begin
            res.estimate = tbl_vals[0];
          end else if (r.key >= tbl_keys[last]) begin
            res.estimate = tbl_vals[last];
          end else begin
            lo = 0;
            hi = last;
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (tbl_keys[mid] < r.key) lo = mid + 1;
              else hi = mid;
            end
            if (lo == 0) lo = 1;
            if (tbl_keys[lo] == r.key) begin
              res.estimate = tbl_vals[lo];
            end else begin
              dx   = tbl_keys[lo] - tbl_keys[lo-1];
              ofs  = r.key - tbl_keys[lo-1];
              y0   = tbl_vals[lo-1];
              y1   = tbl_vals[lo];
              dy   = y1 - y0;
              mag  = (dy < 0) ? -dy : dy;
              quot = (mag * {32'd0, ofs}) / {32'd0, dx};
              est  = (dy < 0) ? y0 - longint'(quot) : y0 + longint'(quot);
              res.estimate = est[31:0];
              n_interp++;
            end
          end
        end
      end
      default: ;
    endcase
    n_status[res.status]++;
    return res;
  endfunction

  task automatic push_req(input logic [1:0] rt, input logic [31:0] k, input logic [31:0] v,
                          input bit drain);
    pending_t p;
    p.req.req_type = rt;
    p.req.key      = k;
    p.req.value    = v;
    p.drain        = drain;
    request_q.insert(request_q.size(), p);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic build_table(input int n, input logic [31:0] max_step, input bit noisy);
    logic [32:0] next;
    built_keys.delete();
    push_req(plk_pkg::REQ_CLEAR, $urandom, $urandom, ($urandom_range(0, 7) == 0));
    for (int i = 0; i < n; i++) begin
      if (noisy && built_keys.size() > 0 && $urandom_range(0, 9) == 0)
        push_req(plk_pkg::REQ_APPEND, built_keys[$urandom_range(0, built_keys.size() - 1)],
                 rand_value(), 1'b0);
      if (noisy && $urandom_range(0, 19) == 0)
        push_req(REQ_UNUSED, $urandom, $urandom, 1'b0);
      if (built_keys.size() == 0) begin
        case ($urandom_range(0, 2))
          0: next = 33'd0;
          1: next = $urandom_range(0, 1000);
          default: next = $urandom;
        endcase
      end else begin
        next = {1'b0, built_keys[$]} + $urandom_range(1, max_step);
      end
      if (next > 33'h0_ffff_ffff) break;
      built_keys.insert(built_keys.size(), next[31:0]);
      push_req(plk_pkg::REQ_APPEND, next[31:0], rand_value(), 1'b0);
    end
  endtask

  task automatic random_queries(input int m);
    logic [31:0] k, lo_key, hi_key;
    int          n, j;
    for (int i = 0; i < m; i++) begin
      n = built_keys.size();
      if (n == 0) begin
        k = $urandom;
      end else begin
        case ($urandom_range(0, 9))
          0: k = $urandom_range(0, built_keys[0]);
          1: k = $urandom_range(built_keys[n-1], 32'hffff_ffff);
          2, 3: k = built_keys[$urandom_range(0, n - 1)];
          4: k = $urandom;
          default: begin
            if (n < 2) begin
              k = $urandom;
            end else begin
              j      = $urandom_range(1, n - 1);
              lo_key = built_keys[j-1];
              hi_key = built_keys[j];
              if (hi_key - lo_key >= 2) k = lo_key + $urandom_range(1, hi_key - lo_key - 1);
              else k = hi_key;
            end
          end
        endcase
      end
      push_req(plk_pkg::REQ_QUERY, k, $urandom, 1'b0);
    end
  endtask

  // monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    plk_pkg::out_t exp_res;
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        awaited_results.insert(awaited_results.size(), apply_request(in_data));
        in_count++;
      end
      if (out_valid && !out_stall) begin
        out_count++;
        if (awaited_results.size() == 0) begin
          $error("result transfer with no request outstanding: estimate %h status %0d",
                 out_data.estimate, out_data.status);
          errors++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (out_data.estimate !== exp_res.estimate) begin
            $error("estimate mismatch: expected %h, actual %h", exp_res.estimate,
                   out_data.estimate);
            errors++;
          end
          if (out_data.status !== exp_res.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_res.status,
                   out_data.status);
            errors++;
          end
        end
      end
    end
  end

  // request driver: bursts with random gaps, optional drain before an item
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fired) begin
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (request_q.size() == 0 ||
                 (request_q[0].drain && awaited_results.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      in_data  <= request_q[0].req;
      in_valid <= 1'b1;
      request_q.pop_front();
      if (burst_left <= 1) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 30);
        gap_left   = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  end

  // result receiver: changing stall modes plus long hold-offs
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (holdoffs_done < 2 && in_count >= 300 + 400 * holdoffs_done) begin
      out_stall <= 1'b1;
      hold_left = $urandom_range(300, 500);
      holdoffs_done++;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    // directed: empty table, single knot, full-range span, order errors, unused code
    push_req(plk_pkg::REQ_QUERY, 32'd0, 32'hffff_ffff, 1'b0);
    push_req(REQ_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    push_req(plk_pkg::REQ_APPEND, 32'd0, 32'h8000_0000, 1'b0);
    push_req(plk_pkg::REQ_QUERY, 32'd0, 32'd0, 1'b0);
    push_req(plk_pkg::REQ_QUERY, 32'hffff_ffff, 32'd0, 1'b0);
    push_req(plk_pkg::REQ_APPEND, 32'd0, 32'd1, 1'b0);
    push_req(plk_pkg::REQ_APPEND, 32'hffff_ffff, 32'h7fff_ffff, 1'b0);
    push_req(plk_pkg::REQ_QUERY, 32'h8000_0000, 32'd0, 1'b0);
    push_req(plk_pkg::REQ_QUERY, 32'hffff_fffe, 32'd0, 1'b0);
    push_req(plk_pkg::REQ_QUERY, 32'd1, 32'd0, 1'b0);
    push_req(plk_pkg::REQ_QUERY, 32'hffff_ffff, 32'd0, 1'b0);
    push_req(plk_pkg::REQ_APPEND, 32'd5, 32'd7, 1'b0);
    push_req(plk_pkg::REQ_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    push_req(plk_pkg::REQ_QUERY, 32'd100, 32'd0, 1'b0);
    push_req(plk_pkg::REQ_APPEND, 32'd100, 32'h7fff_ffff, 1'b0);
    push_req(plk_pkg::REQ_APPEND, 32'd102, 32'h8000_0000, 1'b0);
    push_req(plk_pkg::REQ_APPEND, 32'd200, 32'h8000_0000, 1'b0);
    push_req(plk_pkg::REQ_APPEND, 32'd300, 32'd12345, 1'b0);
    push_req(plk_pkg::REQ_QUERY, 32'd50, 32'd0, 1'b0);
    push_req(plk_pkg::REQ_QUERY, 32'd101, 32'd0, 1'b0);
    push_req(plk_pkg::REQ_QUERY, 32'd150, 32'd0, 1'b0);
    push_req(plk_pkg::REQ_QUERY, 32'd200, 32'd0, 1'b0);
    push_req(plk_pkg::REQ_QUERY, 32'd250, 32'd0, 1'b0);
    push_req(plk_pkg::REQ_QUERY, 32'd1000, 32'd0, 1'b0);
    push_req(REQ_UNUSED, $urandom, $urandom, 1'b0);

    while (request_q.size() < 470) begin
      case ($urandom_range(0, 9))
        0: build_table($urandom_range(0, 1), 32'd4, 1'b1);
        1: build_table($urandom_range(40, 100), 32'h0100_0000, 1'b1);
        default: begin
          case ($urandom_range(0, 3))
            0: build_table($urandom_range(2, 16), 32'd4, 1'b1);
            1: build_table($urandom_range(2, 16), 32'h0001_0000, 1'b1);
            2: build_table($urandom_range(2, 16), 32'h0100_0000, 1'b1);
            default: build_table($urandom_range(2, 16), 32'h1000_0000, 1'b1);
          endcase
        end
      endcase
      random_queries($urandom_range(3, 20));
    end

    // a large table, then more knots past its end and out of order
    build_table(300, 32'd4_000_000, 1'b0);
    push_req(plk_pkg::REQ_APPEND, 32'hffff_ffff, rand_value(), 1'b0);
    push_req(plk_pkg::REQ_APPEND, built_keys[0], rand_value(), 1'b0);
    random_queries(20);

    fill_start = request_q.size();
    while (request_q.size() < fill_start + 140) begin
      build_table($urandom_range(2, 16), ($urandom_range(0, 1) == 0) ? 32'd8 : 32'h0800_0000,
                  1'b1);
      random_queries($urandom_range(3, 20));
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid || awaited_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("covered %0d requests and %0d results, %0d of them interpolated queries",
             in_count, out_count, n_interp);
    $display("status seen: ok %0d, empty %0d, full %0d, out of order %0d",
             n_status[plk_pkg::ST_OK], n_status[plk_pkg::ST_EMPTY],
             n_status[plk_pkg::ST_FULL], n_status[plk_pkg::ST_ORDER]);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout: %0d results still outstanding", awaited_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
hdl/plk_pkg.sv
hdl/plk_knot_mem.sv
hdl/plk_div.sv
hdl/piecewise_linear_lookup.sv
sim/tb_top.sv
